// File: rtl/core/mwml_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the mecanum wheel mixer with speed limit
package mwml_pkg;

    localparam int SPEED_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_INDEX_W       = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRONT_GAIN  = 2'd0,
        CFG_REAR_GAIN   = 2'd1,
        CFG_SPEED_LIMIT = 2'd2
    } t_cfg_index;

endpackage

// File: rtl/core/mecanum_wheel_mixer_with_limit.sv
`timescale 1ns / 1ps
// mecanum wheel mixer: chassis command to four wheel setpoints with proportional limit
//
// input stream s_axis: one chassis command per word (forward, lateral, yaw rate).
// output stream m_axis: four wheel speed setpoints per word, tuser flags that the
// four wheels were scaled down to the configured limit.
// config port: i_cfg_we / i_cfg_index / i_cfg_data, written only while no word is
// in flight; index 0 front gain, 1 rear gain, 2 wheel speed limit, others ignored.
// pipeline: 8 stages for the split multipliers, the wheel sums, magnitudes and the
// maximum, one stage per quotient bit of the limit scaling (SPEED_WIDTH - 1 stages),
// and the output register.
// throughput: one word per cycle while the skid register is empty; the scaling
// divider is unrolled into one radix-2 step per stage for all four wheels.
// reset: gains go to zero, the limit to all ones, every stage and the output empty.
// stall: the output register plus a one-word skid register absorb a stalled
// receiver; once the skid register holds a word, s_axis_tready drops and the
// whole pipeline holds until the receiver takes the output word.
module mecanum_wheel_mixer_with_limit
    import mwml_pkg::*;
#(
    parameter int SPEED_WIDTH   = SPEED_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int S_TDATA_W    = ((3 * SPEED_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((4 * SPEED_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // forward_speed, lateral_speed, yaw_rate, zero pad
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // wheel_zero_speed, wheel_one_speed, wheel_two_speed, wheel_three_speed, zero pad
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // limited
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [SPEED_WIDTH-1:0] i_cfg_data
);

    localparam int W       = SPEED_WIDTH;
    localparam int F       = FRACTION_BITS;
    localparam int LO_W    = W / 2;
    localparam int HI_W    = W - LO_W;
    localparam int PP_W    = 2 * HI_W;
    localparam int PROD_W  = 2 * W;
    localparam int ROT_W   = 2 * W - 1 - F;
    localparam int SUM_W   = ((W + 2 > ROT_W + 1) ? (W + 2) : (ROT_W + 1)) + 1;
    localparam int QW      = W - 1;
    localparam int DIV_N   = W - 1;
    localparam int NPIPE   = 8 + DIV_N;
    localparam int DL      = DIV_N - 1;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [QW-1:0]    quo;
    } t_div;

    // one restoring step of floor(a * limit / c), digit 0..2 since rem < c and a <= c
    function automatic t_div div_step(input logic [SUM_W-1:0] rem,
                                      input logic [QW-1:0]    quo,
                                      input logic [SUM_W-1:0] a,
                                      input logic [SUM_W-1:0] c,
                                      input logic             lim_bit);
        logic [SUM_W+1:0] t;
        logic [SUM_W+1:0] t1;
        logic [SUM_W+1:0] t2;
        t_div             res;
        t  = ({2'b00, rem} << 1) + (lim_bit ? {2'b00, a} : '0);
        t1 = t - {2'b00, c};
        t2 = t - {1'b0, c, 1'b0};
        if (!t2[SUM_W+1]) begin
            res.rem = t2[SUM_W-1:0];
            res.quo = (quo << 1) + QW'(2);
        end else if (!t1[SUM_W+1]) begin
            res.rem = t1[SUM_W-1:0];
            res.quo = (quo << 1) + QW'(1);
        end else begin
            res.rem = t[SUM_W-1:0];
            res.quo = quo << 1;
        end
        return res;
    endfunction

    // configuration
    logic [W-1:0]  r_front_gain;
    logic [W-1:0]  r_rear_gain;
    logic [W-1:0]  r_front_mag;
    logic [W-1:0]  r_rear_mag;
    logic [QW-1:0] r_limit;
    logic [W-1:0]  w_cfg_mag;

    assign w_cfg_mag = i_cfg_data[W-1] ? (~i_cfg_data + W'(1)) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_gain <= '0;
            r_rear_gain  <= '0;
            r_front_mag  <= '0;
            r_rear_mag   <= '0;
            r_limit      <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRONT_GAIN: begin
                    r_front_gain <= i_cfg_data;
                    r_front_mag  <= w_cfg_mag;
                end
                CFG_REAR_GAIN: begin
                    r_rear_gain <= i_cfg_data;
                    r_rear_mag  <= w_cfg_mag;
                end
                CFG_SPEED_LIMIT: begin
                    r_limit <= i_cfg_data[QW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    logic             w_en;
    logic             w_push;
    logic [NPIPE-1:0] r_valid;
    logic             r_out_valid;
    logic             r_skid_valid;

    assign w_en          = !r_skid_valid;
    assign w_push        = w_en && r_valid[NPIPE-1];
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NPIPE-2:0], s_axis_tvalid};
        end
    end

    // stage payloads
    logic [W-1:0]     w_yaw;
    logic [W-1:0]     r1_vx, r1_vy, r1_yaw_mag;
    logic             r1_neg_f, r1_neg_r;
    logic [W-1:0]     r2_vx, r2_vy;
    logic             r2_neg_f, r2_neg_r;
    logic [PP_W-1:0]  r2_f_ll, r2_f_lh, r2_f_hl, r2_f_hh;
    logic [PP_W-1:0]  r2_r_ll, r2_r_lh, r2_r_hl, r2_r_hh;
    logic [PROD_W-1:0] r3_prod_f, r3_prod_r;
    logic             r3_neg_f, r3_neg_r;
    logic [W:0]       r3_sum, r3_dif;
    logic [ROT_W-1:0] w_rot_f, w_rot_r;
    logic [SUM_W-1:0] r4_rf, r4_rr;
    logic [SUM_W-1:0] r4_sum, r4_dif;
    logic [SUM_W-1:0] r5_w   [4];
    logic [SUM_W-1:0] r6_mag [4];
    logic             r6_sgn [4];
    logic [W-1:0]     r6_lo  [4];
    logic [SUM_W-1:0] r7_mag [4];
    logic             r7_sgn [4];
    logic [W-1:0]     r7_lo  [4];
    logic [SUM_W-1:0] r7_mx01, r7_mx23;
    logic [SUM_W-1:0] r8_mag [4];
    logic             r8_sgn [4];
    logic [W-1:0]     r8_lo  [4];
    logic [SUM_W-1:0] r8_mx;

    assign w_yaw   = s_axis_tdata[3*W-1:2*W];
    assign w_rot_f = ROT_W'(r3_prod_f >> F);
    assign w_rot_r = ROT_W'(r3_prod_r >> F);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: capture, yaw magnitude and product signs
            r1_vx      <= s_axis_tdata[W-1:0];
            r1_vy      <= s_axis_tdata[2*W-1:W];
            r1_yaw_mag <= w_yaw[W-1] ? (~w_yaw + W'(1)) : w_yaw;
            r1_neg_f   <= w_yaw[W-1] ^ r_front_gain[W-1];
            r1_neg_r   <= w_yaw[W-1] ^ r_rear_gain[W-1];

            // stage 2: partial products
            r2_vx    <= r1_vx;
            r2_vy    <= r1_vy;
            r2_neg_f <= r1_neg_f;
            r2_neg_r <= r1_neg_r;
            r2_f_ll  <= PP_W'(r_front_mag[LO_W-1:0]) * PP_W'(r1_yaw_mag[LO_W-1:0]);
            r2_f_lh  <= PP_W'(r_front_mag[LO_W-1:0]) * PP_W'(r1_yaw_mag[W-1:LO_W]);
            r2_f_hl  <= PP_W'(r_front_mag[W-1:LO_W]) * PP_W'(r1_yaw_mag[LO_W-1:0]);
            r2_f_hh  <= PP_W'(r_front_mag[W-1:LO_W]) * PP_W'(r1_yaw_mag[W-1:LO_W]);
            r2_r_ll  <= PP_W'(r_rear_mag[LO_W-1:0]) * PP_W'(r1_yaw_mag[LO_W-1:0]);
            r2_r_lh  <= PP_W'(r_rear_mag[LO_W-1:0]) * PP_W'(r1_yaw_mag[W-1:LO_W]);
            r2_r_hl  <= PP_W'(r_rear_mag[W-1:LO_W]) * PP_W'(r1_yaw_mag[LO_W-1:0]);
            r2_r_hh  <= PP_W'(r_rear_mag[W-1:LO_W]) * PP_W'(r1_yaw_mag[W-1:LO_W]);

            // stage 3: full products, forward/lateral sum and difference
            r3_prod_f <= PROD_W'(r2_f_ll) + (PROD_W'(r2_f_lh) << LO_W)
                       + (PROD_W'(r2_f_hl) << LO_W) + (PROD_W'(r2_f_hh) << (2 * LO_W));
            r3_prod_r <= PROD_W'(r2_r_ll) + (PROD_W'(r2_r_lh) << LO_W)
                       + (PROD_W'(r2_r_hl) << LO_W) + (PROD_W'(r2_r_hh) << (2 * LO_W));
            r3_neg_f  <= r2_neg_f;
            r3_neg_r  <= r2_neg_r;
            r3_sum    <= {r2_vx[W-1], r2_vx} + {r2_vy[W-1], r2_vy};
            r3_dif    <= {r2_vx[W-1], r2_vx} - {r2_vy[W-1], r2_vy};

            // stage 4: rotation terms truncated toward zero
            r4_rf  <= r3_neg_f ? (~SUM_W'(w_rot_f) + SUM_W'(1)) : SUM_W'(w_rot_f);
            r4_rr  <= r3_neg_r ? (~SUM_W'(w_rot_r) + SUM_W'(1)) : SUM_W'(w_rot_r);
            r4_sum <= {{(SUM_W-W-1){r3_sum[W]}}, r3_sum};
            r4_dif <= {{(SUM_W-W-1){r3_dif[W]}}, r3_dif};

            // stage 5: wheel mix
            r5_w[0] <= r4_rf - r4_sum;
            r5_w[1] <= r4_rf + r4_dif;
            r5_w[2] <= r4_rr + r4_sum;
            r5_w[3] <= r4_rr - r4_dif;

            // stage 6: magnitudes
            for (int i = 0; i < 4; i++) begin
                r6_mag[i] <= r5_w[i][SUM_W-1] ? (~r5_w[i] + SUM_W'(1)) : r5_w[i];
                r6_sgn[i] <= r5_w[i][SUM_W-1];
                r6_lo[i]  <= r5_w[i][W-1:0];
            end

            // stage 7: pairwise maximum
            for (int i = 0; i < 4; i++) begin
                r7_mag[i] <= r6_mag[i];
                r7_sgn[i] <= r6_sgn[i];
                r7_lo[i]  <= r6_lo[i];
            end
            r7_mx01 <= (r6_mag[0] > r6_mag[1]) ? r6_mag[0] : r6_mag[1];
            r7_mx23 <= (r6_mag[2] > r6_mag[3]) ? r6_mag[2] : r6_mag[3];

            // stage 8: overall maximum
            for (int i = 0; i < 4; i++) begin
                r8_mag[i] <= r7_mag[i];
                r8_sgn[i] <= r7_sgn[i];
                r8_lo[i]  <= r7_lo[i];
            end
            r8_mx <= (r7_mx01 > r7_mx23) ? r7_mx01 : r7_mx23;
        end
    end

    // scaling divider, one quotient bit per stage
    logic [SUM_W-1:0] r_d_rem [DIV_N][4];
    logic [QW-1:0]    r_d_quo [DIV_N][4];
    logic [SUM_W-1:0] r_d_mag [DIV_N][4];
    logic             r_d_sgn [DIV_N][4];
    logic [W-1:0]     r_d_lo  [DIV_N][4];
    logic [SUM_W-1:0] r_d_mx  [DIV_N];
    logic             r_d_over[DIV_N];
    t_div             n_step  [DIV_N][4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_step[0][i] = div_step('0, '0, r8_mag[i], r8_mx, r_limit[QW-1]);
        end
        for (int j = 1; j < DIV_N; j++) begin
            for (int i = 0; i < 4; i++) begin
                n_step[j][i] = div_step(r_d_rem[j-1][i], r_d_quo[j-1][i], r_d_mag[j-1][i],
                                        r_d_mx[j-1], r_limit[QW-1-j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_mx[0]   <= r8_mx;
            r_d_over[0] <= r8_mx > SUM_W'(r_limit);
            for (int i = 0; i < 4; i++) begin
                r_d_rem[0][i] <= n_step[0][i].rem;
                r_d_quo[0][i] <= n_step[0][i].quo;
                r_d_mag[0][i] <= r8_mag[i];
                r_d_sgn[0][i] <= r8_sgn[i];
                r_d_lo[0][i]  <= r8_lo[i];
            end
            for (int j = 1; j < DIV_N; j++) begin
                r_d_mx[j]   <= r_d_mx[j-1];
                r_d_over[j] <= r_d_over[j-1];
                for (int i = 0; i < 4; i++) begin
                    r_d_rem[j][i] <= n_step[j][i].rem;
                    r_d_quo[j][i] <= n_step[j][i].quo;
                    r_d_mag[j][i] <= r_d_mag[j-1][i];
                    r_d_sgn[j][i] <= r_d_sgn[j-1][i];
                    r_d_lo[j][i]  <= r_d_lo[j-1][i];
                end
            end
        end
    end

    // result word select
    logic [4*W-1:0] n_item_data;
    logic           n_item_limited;
    logic [W-1:0]   w_quo_ext [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_quo_ext[i] = {1'b0, r_d_quo[DL][i]};
            if (r_d_over[DL]) begin
                n_item_data[i*W +: W] = r_d_sgn[DL][i] ? (~w_quo_ext[i] + W'(1)) : w_quo_ext[i];
            end else begin
                n_item_data[i*W +: W] = r_d_lo[DL][i];
            end
        end
        n_item_limited = r_d_over[DL];
    end

    // output register and skid register
    logic [4*W-1:0] r_out_data;
    logic           r_out_limited;
    logic [4*W-1:0] r_skid_data;
    logic           r_skid_limited;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data    <= r_skid_data;
                r_out_limited <= r_skid_limited;
            end else begin
                r_out_data    <= n_item_data;
                r_out_limited <= n_item_limited;
            end
        end else if (w_push) begin
            r_skid_data    <= n_item_data;
            r_skid_limited <= n_item_limited;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_limited;

endmodule

// File: rtl/core/mwml_checker.sv
`timescale 1ns / 1ps
// port-level checker for the mecanum wheel mixer, bound to the top level
module mwml_checker
    import mwml_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
    localparam int M_TDATA_W  = ((4 * SPEED_WIDTH + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    localparam int W = SPEED_WIDTH;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

    // output empties at reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // input backpressure only while a word waits at the output
    a_ready_low_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // backpressure starts only after an output stall
    a_ready_fall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // scaled wheels stay within the limit, so never the most negative code
    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[0*W +: W] != MOST_NEG && m_axis_tdata[1*W +: W] != MOST_NEG &&
            m_axis_tdata[2*W +: W] != MOST_NEG && m_axis_tdata[3*W +: W] != MOST_NEG)
        else $error("scaled wheel out of range");

endmodule

bind mecanum_wheel_mixer_with_limit mwml_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_mwml_checker (.*);
